>>> hw/rtl/hsfp_pkg.sv
// Package for the HMI screen frame parser: constants, state type and control structs.
`timescale 1ns / 1ps
package hsfp_pkg;

  // Width of the byte counter and of the read pointer.
  localparam int CNT_W = 6;
  // Width of the count of results still to be sent.
  localparam int LEFT_W = 5;

  // Default buffer depth in bytes.
  localparam int FRAME_BYTES_DEF = 40;

  // Frame byte codes.
  localparam logic [7:0] HDR_BYTE    = 8'hEE;
  localparam logic [7:0] CMD_A       = 8'hB1;
  localparam logic [7:0] CMD_B       = 8'h11;
  localparam logic [7:0] TYPE_BUTTON = 8'h10;
  localparam logic [7:0] TYPE_TEXT   = 8'h11;
  localparam logic [7:0] FOOT_FF     = 8'hFF;
  localparam logic [7:0] FOOT_FC     = 8'hFC;

  // Frame lengths and positions.
  localparam logic [CNT_W-1:0]  BUTTON_LEN   = CNT_W'(10);
  localparam logic [CNT_W-1:0]  TEXT_MIN     = CNT_W'(13);
  localparam logic [CNT_W-1:0]  PAYLOAD_POS  = CNT_W'(8);
  localparam logic [CNT_W-1:0]  BUTTON_OVH   = CNT_W'(8);
  localparam logic [CNT_W-1:0]  TEXT_OVH     = CNT_W'(12);
  localparam logic [LEFT_W-1:0] RESULT_LIMIT = LEFT_W'(28);

  // Controller states.
  typedef enum logic [2:0] {
    ST_HUNT,
    ST_COLLECT,
    ST_EVAL,
    ST_FIRST,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;       // header byte seen: count becomes one
    logic store;       // write the byte into the buffer
    logic clear;       // count back to zero
    logic rd_first;    // read the first payload byte, load the result count
    logic rd_next;     // read the following payload byte
    logic load_out;    // load a result with data from the read register
    logic load_empty;  // load the single empty result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr_seen;    // incoming byte is the header byte
    logic full;        // buffer holds its full depth
    logic done;        // the frame is complete
    logic good;        // the completed frame has a valid command header
    logic empty;       // the completed frame has no payload to send
    logic out_last;    // the result in the output register is the last one
  } dp_status_t;

endpackage

>>> hw/rtl/hmi_screen_frame_parser.sv
// Top level of the HMI screen frame parser: controller and datapath.
//
//   Channel | Handshake            | Carries
//   --------+----------------------+-----------------------------------------------
//   input   | in_valid / in_ready  | rx_byte
//   output  | out_valid / out_ready| page_id, control_id, control_type,
//           |                      | payload_byte, byte_valid, last
//
// A byte taken while hunting for the header is handled in ST_HUNT alone; a byte taken
// while collecting passes ST_COLLECT, which writes the buffer, and ST_EVAL, which tests
// for a finished frame. A finished frame passes ST_EVAL and ST_FIRST before its first
// result (an empty one skips ST_FIRST), then sends one result a cycle while out_ready
// is high, paced by the single buffer read port.
// Reset returns the parser to hunting for a header; buffer contents are not cleared.
// in_ready is low while a frame is tested or its results are sent.
`timescale 1ns / 1ps
module hmi_screen_frame_parser #(
  parameter int FRAME_BYTES = hsfp_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] page_id,
  output logic [15:0] control_id,
  output logic [7:0]  control_type,
  output logic [7:0]  payload_byte,
  output logic        byte_valid,
  output logic        last
);
  import hsfp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencing of each request and each frame.
  hsfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Buffer and result fields.
  hsfp_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .status       (status),
    .page_id      (page_id),
    .control_id   (control_id),
    .control_type (control_type),
    .payload_byte (payload_byte),
    .byte_valid   (byte_valid),
    .last         (last)
  );

endmodule

>>> hw/rtl/hsfp_datapath.sv
// Datapath of the HMI screen frame parser: buffer, header and tail registers, result register.
`timescale 1ns / 1ps
module hsfp_datapath #(
  parameter int FRAME_BYTES = hsfp_pkg::FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           rx_byte,
  input  hsfp_pkg::dp_cmd_t    cmd,
  output hsfp_pkg::dp_status_t status,
  output logic [15:0]          page_id,
  output logic [15:0]          control_id,
  output logic [7:0]           control_type,
  output logic [7:0]           payload_byte,
  output logic                 byte_valid,
  output logic                 last
);
  import hsfp_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(FRAME_BYTES);

  logic [7:0]        mem [FRAME_BYTES];
  logic [7:0]        rdata;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ptr;
  logic [LEFT_W-1:0] left;
  logic [7:0]        hdr [1:7];
  logic [7:0]        tail [5];

  logic              rd_en;
  logic [CNT_W-1:0]  rd_addr;
  logic              button_done;
  logic              foot_done;
  logic              strip;
  logic [CNT_W-1:0]  plen;
  logic [LEFT_W-1:0] cnt;

  // Byte buffer: one write port, one registered read port.
  assign rd_en   = cmd.rd_first || (cmd.rd_next && (ptr < DEPTH));
  assign rd_addr = cmd.rd_first ? PAYLOAD_POS : ptr;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[count[AW-1:0]] <= rx_byte;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr[AW-1:0]];
    end
  end

  // Byte count and read pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.start) begin
      count <= CNT_W'(1);
    end else if (cmd.store) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      ptr <= PAYLOAD_POS + CNT_W'(1);
    end else if (rd_en) begin
      ptr <= ptr + CNT_W'(1);
    end
  end

  // Header bytes one to seven are captured as they arrive; the last five bytes shift along.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      for (int i = 1; i <= 7; i++) begin
        if (count == CNT_W'(i)) begin
          hdr[i] <= rx_byte;
        end
      end
      tail[0] <= rx_byte;
      for (int i = 1; i < 5; i++) begin
        tail[i] <= tail[i-1];
      end
    end
  end

  // Frame completion and payload length from the registered count.
  assign button_done = (count == BUTTON_LEN) && (hdr[1] == CMD_A) && (hdr[2] == CMD_B)
                       && (hdr[7] == TYPE_BUTTON);
  assign foot_done   = (count >= TEXT_MIN) && (tail[3] == FOOT_FF) && (tail[2] == FOOT_FC)
                       && (tail[1] == FOOT_FF) && (tail[0] == FOOT_FF);
  assign strip       = (hdr[7] == TYPE_TEXT) && (tail[4] == 8'h00);

  always_comb begin
    if (hdr[7] == TYPE_BUTTON) begin
      plen = count - BUTTON_OVH;
    end else begin
      plen = count - TEXT_OVH - CNT_W'(strip);
    end
    if (plen > CNT_W'(RESULT_LIMIT)) begin
      cnt = RESULT_LIMIT;
    end else begin
      cnt = plen[LEFT_W-1:0];
    end
  end

  // Results still to be loaded into the output register.
  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      left <= cnt;
    end else if (cmd.load_out) begin
      left <= left - LEFT_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      payload_byte <= rdata;
      byte_valid   <= 1'b1;
      last         <= (left == LEFT_W'(1));
    end else if (cmd.load_empty) begin
      payload_byte <= 8'h00;
      byte_valid   <= 1'b0;
      last         <= 1'b1;
    end
  end

  assign page_id      = {hdr[3], hdr[4]};
  assign control_id   = {hdr[5], hdr[6]};
  assign control_type = hdr[7];

  // Status to the controller.
  always_comb begin
    status.hdr_seen = (rx_byte == HDR_BYTE);
    status.full     = (count >= DEPTH);
    status.done     = button_done || foot_done;
    status.good     = (hdr[1] == CMD_A) && (hdr[2] == CMD_B);
    status.empty    = (cnt == '0);
    status.out_last = last;
  end

endmodule

>>> hw/rtl/hsfp_ctrl.sv
// Controller of the HMI screen frame parser: hunts, collects, evaluates and sends results.
`timescale 1ns / 1ps
module hsfp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  hsfp_pkg::dp_status_t status,
  output hsfp_pkg::dp_cmd_t    cmd
);
  import hsfp_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_HUNT: begin
        in_ready = 1'b1;
        if (in_valid && status.hdr_seen) begin
          cmd.start  = 1'b1;
          state_next = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.full) begin
            cmd.clear  = 1'b1;
            state_next = ST_HUNT;
          end else begin
            cmd.store  = 1'b1;
            state_next = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        priority if (!status.done) begin
          state_next = ST_COLLECT;
        end else if (!status.good) begin
          cmd.clear  = 1'b1;
          state_next = ST_HUNT;
        end else if (status.empty) begin
          cmd.load_empty = 1'b1;
          state_next     = ST_OUT;
        end else begin
          cmd.rd_first = 1'b1;
          state_next   = ST_FIRST;
        end
      end
      ST_FIRST: begin
        cmd.load_out = 1'b1;
        cmd.rd_next  = 1'b1;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.out_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_HUNT;
          end else begin
            cmd.load_out = 1'b1;
            cmd.rd_next  = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

endmodule

>>> hw/rtl/hsfp_checker.sv
// Port checker for the HMI screen frame parser, bound to the top level.
`timescale 1ns / 1ps
module hsfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  payload_byte,
  input logic        byte_valid,
  input logic        last
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(last))
    else $error("stalled result changed");

  // No request is taken while results are being sent.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // An empty result is always the only and last one of its frame.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last)
    else $error("empty result not marked last");

  // A taken result that is not last is followed at once by the next one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("gap inside a frame's results");

  // After the last result the parser takes bytes again.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid && in_ready)
    else $error("parser did not return to input after last result");

endmodule

bind hmi_screen_frame_parser hsfp_checker u_hsfp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .payload_byte (payload_byte),
  .byte_valid   (byte_valid),
  .last         (last)
);

>>> tb/sv/frame_parser_checker.sv
// Checker for the HMI screen frame parser: predicts results from accepted requests and compares.
`timescale 1ns / 1ps
module frame_parser_checker #(
  parameter int DEPTH = hsfp_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] page_id,
  input  logic [15:0] control_id,
  input  logic [7:0]  control_type,
  input  logic [7:0]  payload_byte,
  input  logic        byte_valid,
  input  logic        last,
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          frames_emitted,
  output int          empty_results
);
  import hsfp_pkg::*;

  typedef struct packed {
    logic [15:0] page_id;
    logic [15:0] control_id;
    logic [7:0]  control_type;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        last;
  } screen_result_t;

  // Predicted parser state.
  logic [7:0]       frame_bytes [DEPTH];
  logic [CNT_W-1:0] byte_count;
  logic             collecting;

  screen_result_t expected_results [$];
  screen_result_t actual, want;

  // Advances the predicted parser by one received byte and queues any results it causes.
  function automatic void predict_from_byte(input logic [7:0] b);
    int n;
    int plen;
    int cnt;
    screen_result_t r;
    if (!collecting) begin
      if (b == HDR_BYTE) begin
        frame_bytes[0] = HDR_BYTE;
        byte_count = CNT_W'(1);
        collecting = 1'b1;
      end
      return;
    end
    // A full buffer swallows the byte and drops the frame.
    if (byte_count >= DEPTH) begin
      collecting = 1'b0;
      byte_count = '0;
      return;
    end
    frame_bytes[byte_count] = b;
    byte_count = byte_count + 1'b1;
    n = byte_count;
    if (!((n == BUTTON_LEN && frame_bytes[1] == CMD_A && frame_bytes[2] == CMD_B &&
           frame_bytes[7] == TYPE_BUTTON) ||
          (n >= TEXT_MIN && frame_bytes[n-4] == FOOT_FF && frame_bytes[n-3] == FOOT_FC &&
           frame_bytes[n-2] == FOOT_FF && frame_bytes[n-1] == FOOT_FF)))
      return;
    collecting = 1'b0;
    byte_count = '0;
    // A finished frame with a wrong command header is discarded silently.
    if (frame_bytes[0] != HDR_BYTE || frame_bytes[1] != CMD_A || frame_bytes[2] != CMD_B)
      return;
    r.page_id      = {frame_bytes[3], frame_bytes[4]};
    r.control_id   = {frame_bytes[5], frame_bytes[6]};
    r.control_type = frame_bytes[7];
    // Button payload is everything after the type; others lose the footer, text its trailing zero.
    if (r.control_type == TYPE_BUTTON) begin
      plen = n - 8;
    end else begin
      plen = n - 12;
      if (r.control_type == TYPE_TEXT && plen > 0 && frame_bytes[8 + plen - 1] == 8'h00)
        plen--;
    end
    cnt = (plen > int'(RESULT_LIMIT)) ? int'(RESULT_LIMIT) : plen;
    frames_emitted++;
    if (cnt == 0) begin
      r.payload_byte = 8'h00;
      r.byte_valid   = 1'b0;
      r.last         = 1'b1;
      expected_results.push_back(r);
      empty_results++;
      return;
    end
    for (int k = 0; k < cnt; k++) begin
      r.payload_byte = frame_bytes[8 + k];
      r.byte_valid   = 1'b1;
      r.last         = (k + 1 == cnt);
      expected_results.push_back(r);
    end
  endfunction

  initial begin
    collecting = 1'b0;
    byte_count = '0;
  end

  // Results are compared before the request of the same edge is predicted.
  always @(posedge clk) begin
    if (rst) begin
      collecting = 1'b0;
      byte_count = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        actual = {page_id, control_id, control_type, payload_byte, byte_valid, last};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result screen %h control %h type %h byte %h valid %b last %b",
                     $time, page_id, control_id, control_type, payload_byte, byte_valid, last);
        end else begin
          want = expected_results.pop_front();
          if (actual !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: expected screen %h control %h type %h byte %h valid %b last %b",
                       $time, want.page_id, want.control_id, want.control_type,
                       want.payload_byte, want.byte_valid, want.last);
              $display("%0t:      got screen %h control %h type %h byte %h valid %b last %b",
                       $time, page_id, control_id, control_type, payload_byte, byte_valid,
                       last);
            end
          end
        end
      end
      if (in_valid && in_ready) predict_from_byte(rx_byte);
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/sv/testbench.sv
// Testbench top for the HMI screen frame parser: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import hsfp_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int BYTES_PER_PHASE = 120;
  localparam int TAIL_CYCLES     = 40;

  typedef enum int {
    FK_BUTTON,
    FK_TEXT,
    FK_OTHER,
    FK_BAD_HDR,
    FK_OVERFLOW,
    FK_BROKEN,
    FK_NOISE
  } frame_kind_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] page_id;
  logic [15:0] control_id;
  logic [7:0]  control_type;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic        last;

  int fail_count, pending, results_checked, frames_emitted, empty_results;
  int src_idle_pct, sink_stall_pct;
  int bytes_sent, frames_sent, quiet_cycles;
  logic [7:0] frame_q [$];

  hmi_screen_frame_parser uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .page_id(page_id), .control_id(control_id), .control_type(control_type),
    .payload_byte(payload_byte), .byte_valid(byte_valid), .last(last)
  );

  frame_parser_checker checker_inst (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .page_id(page_id), .control_id(control_id), .control_type(control_type),
    .payload_byte(payload_byte), .byte_valid(byte_valid), .last(last),
    .fail_count(fail_count), .pending(pending), .results_checked(results_checked),
    .frames_emitted(frames_emitted), .empty_results(empty_results)
  );

  // 2 ns clock.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Result side: ready drops at random according to the current stall rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: ends the run when no request moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("No request accepted for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // Sends the bytes held in frame_q, with random idle cycles ahead of each one.
  task automatic send_queued(input bit counted);
    foreach (frame_q[i]) begin
      @(negedge clk);
      while ($urandom_range(99) < src_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      rx_byte  <= frame_q[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    if (counted) begin
      bytes_sent += frame_q.size();
      frames_sent++;
    end
  endtask

  // Builds one byte sequence of the given kind and sends it.
  task automatic send_frame(input frame_kind_t kind);
    int len;
    int zero;
    int sel;
    logic [7:0] ftype;
    frame_q.delete();
    case (kind)
      FK_NOISE: begin
        repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
      end
      // Header then random bytes until the buffer is full; the next byte is swallowed.
      FK_OVERFLOW: begin
        frame_q.push_back(HDR_BYTE);
        repeat (FRAME_BYTES_DEF - 1) frame_q.push_back(8'($urandom));
        frame_q.push_back($urandom_range(1) ? HDR_BYTE : 8'($urandom));
      end
      default: begin
        if (kind == FK_BUTTON) begin
          ftype = TYPE_BUTTON;
        end else if (kind == FK_TEXT) begin
          ftype = TYPE_TEXT;
        end else if (kind == FK_OTHER) begin
          do ftype = 8'($urandom); while (ftype == TYPE_BUTTON);
        end else begin
          ftype = 8'($urandom);
        end
        frame_q.push_back(HDR_BYTE);
        frame_q.push_back(CMD_A);
        frame_q.push_back(CMD_B);
        repeat (4) frame_q.push_back(8'($urandom));
        frame_q.push_back(ftype);
        // Corrupt one or both command bytes.
        if (kind == FK_BAD_HDR) begin
          sel = $urandom_range(2);
          if (sel != 1) frame_q[1] = CMD_A ^ 8'($urandom_range(1, 255));
          if (sel != 0) frame_q[2] = CMD_B ^ 8'($urandom_range(1, 255));
        end
        if (kind == FK_BUTTON) begin
          repeat (2) frame_q.push_back(8'($urandom));
        end else if (kind == FK_BROKEN) begin
          // Cut short: the following bytes run on into the same buffer.
          repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom));
        end else begin
          // Mostly short payloads, now and then one that fills the buffer to its depth.
          zero = $urandom_range(1);
          if ($urandom_range(7) == 0)
            len = $urandom_range(1) ? 28 - zero : $urandom_range(28 - zero);
          else
            len = $urandom_range(6);
          repeat (len) frame_q.push_back(8'($urandom));
          if (zero != 0) frame_q.push_back(8'h00);
          frame_q.push_back(FOOT_FF);
          frame_q.push_back(FOOT_FC);
          frame_q.push_back(FOOT_FF);
          frame_q.push_back(FOOT_FF);
        end
      end
    endcase
    send_queued(kind != FK_NOISE);
  endtask

  initial begin
    int pick;
    frame_kind_t kind;
    rst            = 1'b1;
    in_valid       = 1'b0;
    rx_byte        = 8'h00;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme bytes while idle, a button frame, and a text frame left empty by stripping.
    frame_q = '{8'h00, 8'hFF};
    send_queued(1'b0);
    frame_q = '{HDR_BYTE, CMD_A, CMD_B, 8'hFF, 8'hFF, 8'h00, 8'h00, TYPE_BUTTON, 8'h00, 8'hFF};
    send_queued(1'b1);
    frame_q = '{HDR_BYTE, CMD_A, CMD_B, 8'h00, 8'h00, 8'hFF, 8'hFF, TYPE_TEXT, 8'h00,
                FOOT_FF, FOOT_FC, FOOT_FF, FOOT_FF};
    send_queued(1'b1);

    // Random frames in four pacing phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 77; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 77; end
        default: begin src_idle_pct = 17; sink_stall_pct = 17; end
      endcase
      while (bytes_sent < (phase + 1) * BYTES_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 25)      kind = FK_BUTTON;
        else if (pick < 55) kind = FK_TEXT;
        else if (pick < 70) kind = FK_OTHER;
        else if (pick < 80) kind = FK_BAD_HDR;
        else if (pick < 85) kind = FK_OVERFLOW;
        else if (pick < 92) kind = FK_BROKEN;
        else                kind = FK_NOISE;
        send_frame(kind);
      end
    end

    // Drain the outstanding results, then let the parser settle.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d frame bytes in %0d sequences: button, text, other-type, bad-header,",
             bytes_sent, frames_sent);
    $display("overflow and truncated frames; checked %0d results from %0d frames, %0d empty.",
             results_checked, frames_emitted, empty_results);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
